// ===== design/mesh_cell_occupancy_histogram_defines.svh =====
// assertion macros for the checker file of the mesh cell histogram
`ifndef MESH_CELL_OCCUPANCY_HISTOGRAM_DEFINES_SVH
`define MESH_CELL_OCCUPANCY_HISTOGRAM_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define MCOH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define MCOH_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

// ===== design/mcoh_pkg.sv =====
// types and constants shared by the mesh cell histogram modules
`default_nettype none

package mcoh_pkg;

    // field widths of the stream words
    localparam int POS_W         = 32;
    localparam int CELL_FIELD_W  = 12;
    localparam int COUNT_FIELD_W = 20;
    localparam int IN_TDATA_W    = 6 * POS_W;
    localparam int OUT_TDATA_W   = 72;
    localparam int OUT_USED_W    = 2 * CELL_FIELD_W + 2 * COUNT_FIELD_W + 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MESH_REG_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_Z      = 3'd5;

    localparam logic [POS_W-1:0]      CELL_SIZE_RESET = 32'h0001_0000;
    localparam logic [MESH_REG_W-1:0] MESH_RESET      = 5'd16;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_LIN0,
        ST_LIN1,
        ST_RD,
        ST_UPD,
        ST_DONE
    } state_t;

    // which position of the word is being worked on
    typedef enum logic {
        PH_OLD,
        PH_NEW
    } phase_t;

    // command to the count memory
    typedef struct packed {
        logic rd;
        logic upd;
        logic dec;
    } mem_cmd_t;

endpackage

`default_nettype wire

// ===== design/mcoh_axis_div.sv =====
// iterative restoring divider giving a clamped cell coordinate on one axis
`default_nettype none

module mcoh_axis_div
    import mcoh_pkg::*;
#(
    parameter int QBITS = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [POS_W-1:0] pos,
    input  wire logic [POS_W-1:0] size,
    input  wire logic [QBITS-1:0] dim_m1,
    output logic                  done,
    output logic      [QBITS-1:0] coord
);

    localparam int DW = POS_W + QBITS;
    localparam int SW = $clog2(QBITS + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] step_reg;
    logic [POS_W-1:0] rem_reg;
    logic [DW-1:0]    dvs_reg;
    logic [QBITS:0]   q_reg;
    logic [DW:0]      trial;
    logic [POS_W-1:0] size_eff;

    // a zero size counts as the smallest step
    assign size_eff = (size == '0) ? POS_W'(1) : size;

    // one compare and subtract per cycle, divisor walks down one bit
    assign trial = {1'b0, {QBITS{1'b0}}, rem_reg} - {1'b0, dvs_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= SW'(QBITS);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath; the top quotient bit only marks a quotient past the mesh
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= pos[POS_W-1] ? '0 : pos;
            dvs_reg <= {size_eff, {QBITS{1'b0}}};
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (!trial[DW]) begin
                rem_reg <= trial[POS_W-1:0];
            end
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= {q_reg[QBITS-1:0], ~trial[DW]};
        end
    end

    assign done  = done_reg;
    assign coord = (q_reg > {1'b0, dim_m1}) ? dim_m1 : q_reg[QBITS-1:0];

endmodule

`default_nettype wire

// ===== design/mcoh_count_mem.sv =====
// count table with saturating read-modify-write and a clearing pass after reset
`default_nettype none

module mcoh_count_mem
    import mcoh_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int CW    = 20
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire mem_cmd_t      cmd,
    input  wire logic [AW-1:0] addr,
    output logic               clr_busy,
    output logic      [CW-1:0] upd_val,
    output logic               upd_sat
);

    logic [CW-1:0] mem [DEPTH];
    logic [CW-1:0] rdata_reg;
    logic [AW-1:0] addr_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // clearing sweep, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // single write port
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.upd) begin
            mem[addr_reg] <= upd_val;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rdata_reg <= mem[addr];
            addr_reg  <= addr;
        end
    end

    // saturating step on the word just read
    always_comb begin
        if (cmd.dec) begin
            upd_sat = (rdata_reg == '0);
            upd_val = upd_sat ? rdata_reg : rdata_reg - 1'b1;
        end else begin
            upd_sat = &rdata_reg;
            upd_val = upd_sat ? rdata_reg : rdata_reg + 1'b1;
        end
    end

    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

// ===== design/mesh_cell_occupancy_histogram.sv =====
// mesh cell occupancy histogram: counts particles per cell of a 3-d mesh
//
// s_ channel: one word per request; s_tuser is the request kind (insert or move),
// s_tdata the old and new positions in signed Q16.16. m_ channel: one word per
// request with both cell indices, the counts after the update and the two
// saturation flags. cfg_ port writes cell sizes and mesh dimensions; it is always
// ready; the user must write it only while the block is idle (not enforced here).
// Each axis coordinate comes from one shared restoring divider that runs Q+1
// compare-subtract steps (Q = clog2(MAX_CELLS_PER_AXIS)), three axes per position,
// then two multiply-add steps form the linear index and the count table does a
// read and a write; one request at a time.
// The next request is taken while a result still waits on m_tready; a finished
// request waits for the output register to empty before the block goes idle.
// After reset the count table is swept to zero, one entry a cycle, through all
// MAX_CELLS_PER_AXIS**3 entries (4096 at the default) before s_tready rises.
// Control and configuration registers are reset; the payload registers are not.
`default_nettype none

module mesh_cell_occupancy_histogram
    import mcoh_pkg::*;
#(
    parameter int MAX_CELLS_PER_AXIS = 16,
    parameter int COUNT_WIDTH        = 20
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // old_x, old_y, old_z, new_x, new_y, new_z
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // req_type
    input  wire logic                   s_tuser,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // old_cell, new_cell, old_count, new_count, count_underflow, count_overflow
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int QBITS     = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
    localparam int NUM_CELLS = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
    localparam int IW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

    state_t state_reg, state_next;
    phase_t phase_reg;
    logic [1:0] axis_reg;

    logic [POS_W-1:0]      csize_reg [3];
    logic [MESH_REG_W-1:0] mesh_reg  [3];
    logic [QBITS-1:0]      dim_m1    [3];
    logic [QBITS:0]        dim_n     [3];

    logic             req_type_reg;
    logic [POS_W-1:0] old_pos_reg [3];
    logic [POS_W-1:0] new_pos_reg [3];
    logic [QBITS-1:0] coord_reg   [3];
    logic [IW-1:0]    idx_reg;

    logic [IW-1:0]          old_cell_reg, new_cell_reg;
    logic [COUNT_WIDTH-1:0] old_cnt_reg, new_cnt_reg;
    logic                   under_reg, over_reg;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic             div_start, div_done;
    logic [POS_W-1:0] div_pos;
    logic [QBITS-1:0] div_coord;

    mem_cmd_t               mem_cmd;
    logic                   clr_busy;
    logic [COUNT_WIDTH-1:0] upd_val;
    logic                   upd_sat;

    logic [IW-1:0] lin_a, lin_b, lin_c, lin_res;
    logic          out_free;
    logic          in_acc;

    // mesh size as used: zero means one, above the maximum saturates
    function automatic logic [QBITS-1:0] dim_m1_of(input logic [MESH_REG_W-1:0] d);
        if (d == '0) begin
            return '0;
        end else if (32'(d) > MAX_CELLS_PER_AXIS) begin
            return QBITS'(MAX_CELLS_PER_AXIS - 1);
        end else begin
            return QBITS'(d - 1'b1);
        end
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dim_m1[i] = dim_m1_of(mesh_reg[i]);
            dim_n[i]  = {1'b0, dim_m1[i]} + 1'b1;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                csize_reg[i] <= CELL_SIZE_RESET;
                mesh_reg[i]  <= MESH_RESET;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CELL_SIZE_X: csize_reg[0] <= cfg_data;
                CFG_CELL_SIZE_Y: csize_reg[1] <= cfg_data;
                CFG_CELL_SIZE_Z: csize_reg[2] <= cfg_data;
                CFG_MESH_X:      mesh_reg[0]  <= cfg_data[MESH_REG_W-1:0];
                CFG_MESH_Y:      mesh_reg[1]  <= cfg_data[MESH_REG_W-1:0];
                CFG_MESH_Z:      mesh_reg[2]  <= cfg_data[MESH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // shared divider for all six axis quotients
    assign div_pos = (phase_reg == PH_OLD) ? old_pos_reg[axis_reg] : new_pos_reg[axis_reg];

    mcoh_axis_div #(
        .QBITS (QBITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pos     (div_pos),
        .size    (csize_reg[axis_reg]),
        .dim_m1  (dim_m1[axis_reg]),
        .done    (div_done),
        .coord   (div_coord)
    );

    mcoh_count_mem #(
        .DEPTH (NUM_CELLS),
        .AW    (IW),
        .CW    (COUNT_WIDTH)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (mem_cmd),
        .addr     (idx_reg),
        .clr_busy (clr_busy),
        .upd_val  (upd_val),
        .upd_sat  (upd_sat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (!clr_busy) state_next = ST_IDLE;
            ST_IDLE:     if (in_acc) state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (axis_reg == 2'd2) ? ST_LIN0 : ST_DIV_GO;
                end
            end
            ST_LIN0:     state_next = ST_LIN1;
            ST_LIN1:     state_next = ST_RD;
            ST_RD:       state_next = ST_UPD;
            ST_UPD:      state_next = (phase_reg == PH_OLD) ? ST_DIV_GO : ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready    = 1'b0;
        div_start   = 1'b0;
        mem_cmd     = '0;
        lin_a       = IW'(coord_reg[0]);
        lin_b       = IW'(dim_n[1]);
        lin_c       = IW'(coord_reg[1]);
        unique case (state_reg)
            ST_IDLE:   s_tready  = 1'b1;
            ST_DIV_GO: div_start = 1'b1;
            ST_LIN1: begin
                lin_a = idx_reg;
                lin_b = IW'(dim_n[2]);
                lin_c = IW'(coord_reg[2]);
            end
            ST_RD:     mem_cmd.rd = 1'b1;
            ST_UPD: begin
                mem_cmd.upd = 1'b1;
                mem_cmd.dec = (phase_reg == PH_OLD);
            end
            default: ;
        endcase
    end

    // linear index by horner steps: (x*ny + y)*nz + z
    assign lin_res = lin_a * lin_b + lin_c;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            phase_reg   <= PH_NEW;
            axis_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // output word: loaded when finished and free, cleared when taken
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        phase_reg <= s_tuser ? PH_OLD : PH_NEW;
                        axis_reg  <= '0;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done && axis_reg != 2'd2) begin
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                ST_UPD: begin
                    phase_reg <= PH_NEW;
                    axis_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    req_type_reg <= s_tuser;
                    for (int i = 0; i < 3; i++) begin
                        old_pos_reg[i] <= s_tdata[i*POS_W +: POS_W];
                        new_pos_reg[i] <= s_tdata[(i+3)*POS_W +: POS_W];
                    end
                    // an insert reports zeros for the old cell
                    old_cell_reg <= '0;
                    old_cnt_reg  <= '0;
                    under_reg    <= 1'b0;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    coord_reg[axis_reg] <= div_coord;
                end
            end
            ST_LIN0, ST_LIN1: idx_reg <= lin_res;
            ST_UPD: begin
                if (phase_reg == PH_OLD) begin
                    old_cell_reg <= idx_reg;
                    old_cnt_reg  <= upd_val;
                    under_reg    <= upd_sat;
                end else begin
                    new_cell_reg <= idx_reg;
                    new_cnt_reg  <= upd_val;
                    over_reg     <= upd_sat;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_reg <= {
                        {(OUT_TDATA_W - OUT_USED_W){1'b0}},
                        over_reg,
                        under_reg & req_type_reg,
                        COUNT_FIELD_W'(new_cnt_reg),
                        COUNT_FIELD_W'(old_cnt_reg),
                        CELL_FIELD_W'(new_cell_reg),
                        CELL_FIELD_W'(old_cell_reg)
                    };
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== design/mcoh_checker.sv =====
// port checker for the mesh cell histogram and its bind to the top level
`default_nettype none

`include "mesh_cell_occupancy_histogram_defines.svh"

module mcoh_checker
    import mcoh_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int OLD_CNT_LSB = 2 * CELL_FIELD_W;
    localparam int UNDER_BIT   = 2 * CELL_FIELD_W + 2 * COUNT_FIELD_W;

    // a waiting result word stays offered
    `MCOH_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")

    // and keeps its contents
    `MCOH_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result word changed while stalled")

    // one request at a time: busy right after taking a word
    `MCOH_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    // an underflow leaves the old cell at zero
    `MCOH_ASSERT_NEVER(a_under_zero, m_tvalid && m_tdata[UNDER_BIT] && (m_tdata[OLD_CNT_LSB +: COUNT_FIELD_W] != '0), "underflow with nonzero old count")

endmodule

bind mesh_cell_occupancy_histogram mcoh_checker u_mcoh_checker (.*);

`default_nettype wire
